// ----- rtl/alc_pkg.sv -----
package alc_pkg;

    // configuration port layout
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 32;
    localparam int COUNT_REG_W = 7;

    // register select, taken from address bit 2
    localparam logic REG_ELEMENT_COUNT = 1'b0;
    localparam logic REG_LINKAGE_MODE  = 1'b1;

    // linkage modes
    localparam logic MODE_COMPLETE = 1'b0;
    localparam logic MODE_AVERAGE  = 1'b1;

    // reset values of the registers
    localparam logic [COUNT_REG_W-1:0] ELEMENT_COUNT_RST = 7'd64;
    localparam logic                   LINKAGE_MODE_RST  = MODE_AVERAGE;

    // status of the shared divider
    typedef struct packed {
        logic busy;
        logic done;
    } alc_div_stat_t;

endpackage

// ----- rtl/alc_divider.sv -----
module alc_divider
    import alc_pkg::*;
#(
    parameter int NUM_W = 23,
    parameter int DEN_W = 7
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    output logic [NUM_W-1:0] quo,
    output alc_div_stat_t    stat
);

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic [NUM_W-1:0] quo_reg;
    logic [DEN_W-1:0] rem_reg;
    logic [DEN_W-1:0] den_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             busy_reg;
    logic             done_reg;

    logic [DEN_W:0]   trial;
    logic             fits;
    logic [DEN_W:0]   diff;

    // one restoring step: shift in the next numerator bit, subtract when it fits
    always_comb
    begin
        trial = {rem_reg, quo_reg[NUM_W-1]};
        fits  = (trial >= {1'b0, den_reg});
        diff  = trial - {1'b0, den_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(NUM_W);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - CNT_W'(1);
                if (cnt_reg == CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // datapath, numerator shifts out as the quotient shifts in
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= num;
            rem_reg <= '0;
            den_reg <= den;
        end
        else if (busy_reg)
        begin
            quo_reg <= {quo_reg[NUM_W-2:0], fits};
            rem_reg <= fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
        end
    end

    assign quo       = quo_reg;
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

endmodule

// ----- rtl/agglomerative_linkage_clustering.sv -----
// channel   | direction | handshake           | payload
// ----------+-----------+---------------------+----------------------------------------------
// input     | in        | in_valid / in_stall | distance
// result    | out       | out_valid/out_stall | left_cluster, right_cluster, merge_distance,
//           |           |                     | last_merge
// config    | in        | apb psel/penable    | element_count (0x0), linkage_mode (0x4)
//
// loading takes one matrix entry per cycle while in_valid holds, through the store's single port
// each merge with n active clusters: after a label init done once per load, a scan of all
// n(n-1)/2 pairs, label reads and an emit, then per remaining cluster a read, combine and
// write-back of its distance (complete: maximum; average: size-weighted mean from the
// bit-serial divider), then moves of the last row into the freed row; each memory has one port
// reset clears control only, the memories need no clearing pass since the load fills them
// while merging the input is stalled; a pending result stalls the next merge record only
module agglomerative_linkage_clustering
    import alc_pkg::*;
#(
    parameter int MAX_ELEMENTS = 64,
    parameter int DIST_WIDTH   = 16
) (
    input  logic                          clk,
    input  logic                          rst_n,
    // input channel
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [DIST_WIDTH-1:0]         distance,
    // result channel
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic signed [$clog2(MAX_ELEMENTS):0] left_cluster,
    output logic signed [$clog2(MAX_ELEMENTS):0] right_cluster,
    output logic [DIST_WIDTH-1:0]         merge_distance,
    output logic                          last_merge,
    // configuration port
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [CFG_ADDR_W-1:0]         paddr,
    input  logic [CFG_DATA_W-1:0]         pwdata,
    output logic [CFG_DATA_W-1:0]         prdata,
    output logic                          pready
);

    localparam int IW    = (MAX_ELEMENTS > 2) ? $clog2(MAX_ELEMENTS) : 1;
    localparam int CW    = $clog2(MAX_ELEMENTS + 1);
    localparam int ID_W  = $clog2(MAX_ELEMENTS) + 1;
    localparam int DEPTH = MAX_ELEMENTS * (MAX_ELEMENTS - 1) / 2;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int NUM_W = DIST_WIDTH + CW;
    localparam int NODE_W = ID_W + CW;

    typedef enum logic [19:0] {
        ST_LOAD    = 20'h00001,
        ST_INIT    = 20'h00002,
        ST_SCAN    = 20'h00004,
        ST_LAB_A   = 20'h00008,
        ST_LAB_B   = 20'h00010,
        ST_LAB_C   = 20'h00020,
        ST_LAB_D   = 20'h00040,
        ST_EMIT    = 20'h00080,
        ST_UPD_RA  = 20'h00100,
        ST_UPD_RB  = 20'h00200,
        ST_UPD_OPB = 20'h00400,
        ST_UPD_M1  = 20'h00800,
        ST_UPD_M2  = 20'h01000,
        ST_UPD_DS  = 20'h02000,
        ST_UPD_DW  = 20'h04000,
        ST_UPD_WR  = 20'h08000,
        ST_MV_RD   = 20'h10000,
        ST_MV_WR   = 20'h20000,
        ST_FIX_A   = 20'h40000,
        ST_FIX_B   = 20'h80000
    } state_t;

    // address of pair (x, y) in the packed lower triangle
    function automatic logic [AW-1:0] pair_addr(input logic [IW-1:0] x, input logic [IW-1:0] y);
        logic [IW-1:0]   r;
        logic [IW-1:0]   c;
        logic [2*IW-1:0] p;
        begin
            r = (x > y) ? x : y;
            c = (x > y) ? y : x;
            p = (2*IW)'(r) * (2*IW)'(r - IW'(1));
            pair_addr = AW'((p >> 1) + (2*IW)'(c));
        end
    endfunction

    state_t state_reg;

    // configuration
    logic [COUNT_REG_W-1:0] elem_cnt_reg;
    logic                   mode_reg;
    logic                   cfg_wr;

    // load and merge control
    logic [AW-1:0]   load_pos_reg;
    logic [CW-1:0]   n_reg;
    logic [CW-1:0]   total_reg;
    logic [IW-1:0]   sc_i_reg;
    logic [IW-1:0]   sc_j_reg;
    logic            sc_done_reg;
    logic            p_vld_reg;
    logic            p_first_reg;
    logic [IW-1:0]   p_i_reg;
    logic [IW-1:0]   p_j_reg;
    logic [DIST_WIDTH-1:0] best_reg;
    logic [IW-1:0]   bi_reg;
    logic [IW-1:0]   bj_reg;
    logic [IW-1:0]   cnt_reg;

    // cluster words and operands
    logic [ID_W-1:0] la_reg;
    logic [ID_W-1:0] lb_reg;
    logic [ID_W-1:0] ll_reg;
    logic [CW-1:0]   ca_reg;
    logic [CW-1:0]   cb_reg;
    logic [CW-1:0]   cl_reg;
    logic [DIST_WIDTH-1:0] op_a_reg;
    logic [DIST_WIDTH-1:0] op_b_reg;
    logic [NUM_W-1:0] prod_reg;
    logic [NUM_W-1:0] wsum_reg;

    // result register
    logic                  out_valid_reg;
    logic [ID_W-1:0]       left_reg;
    logic [ID_W-1:0]       right_reg;
    logic [DIST_WIDTH-1:0] mdist_reg;
    logic                  last_reg;

    // memories
    logic [DIST_WIDTH-1:0] store [DEPTH];
    logic [DIST_WIDTH-1:0] st_q;
    logic [AW-1:0]         st_addr;
    logic                  st_we;
    logic [DIST_WIDTH-1:0] st_wd;
    logic [NODE_W-1:0]     nodes [MAX_ELEMENTS];
    logic [NODE_W-1:0]     node_q;
    logic [IW-1:0]         node_addr;
    logic                  node_we;
    logic [NODE_W-1:0]     node_wd;

    // divider
    logic                  div_start;
    logic [NUM_W-1:0]      div_quo;
    alc_div_stat_t         div_stat;

    // derived values
    logic [CW-1:0]   eff_n;
    logic [2*CW-1:0] tri_prod;
    logic [AW:0]     entries;
    logic [AW-1:0]   load_addr;
    logic            in_xfer;
    logic            out_free;
    logic [IW-1:0]   nlast;
    logic [IW-1:0]   nlast2;
    logic            sc_row_end;
    logic [IW-1:0]   pa_x;
    logic [IW-1:0]   pa_y;
    logic [CW-1:0]   sum_c;
    logic [ID_W-1:0] new_label;
    logic [DIST_WIDTH-1:0] upd_val;

    // clamp the element count and size the triangle
    always_comb
    begin
        if (elem_cnt_reg < COUNT_REG_W'(2))
            eff_n = CW'(2);
        else if (32'(elem_cnt_reg) > 32'(MAX_ELEMENTS))
            eff_n = CW'(MAX_ELEMENTS);
        else
            eff_n = CW'(elem_cnt_reg);
        tri_prod = (2*CW)'(eff_n) * (2*CW)'(eff_n - CW'(1));
        entries  = (AW+1)'(tri_prod >> 1);
    end

    assign load_addr  = ({1'b0, load_pos_reg} >= entries) ? '0 : load_pos_reg;
    assign in_stall   = (state_reg != ST_LOAD);
    assign in_xfer    = in_valid && !in_stall;
    assign out_free   = !out_valid_reg || !out_stall;
    assign nlast      = IW'(n_reg - CW'(1));
    assign nlast2     = IW'(n_reg - CW'(2));
    assign sc_row_end = (sc_j_reg == sc_i_reg - IW'(1));
    assign sum_c      = ca_reg + cb_reg;
    assign new_label  = ID_W'(n_reg) - ID_W'(total_reg) - ID_W'(1);
    assign upd_val    = (mode_reg == MODE_COMPLETE) ?
                        ((op_a_reg > op_b_reg) ? op_a_reg : op_b_reg) :
                        DIST_WIDTH'(div_quo);

    // memory port selection
    always_comb
    begin
        pa_x      = sc_i_reg;
        pa_y      = sc_j_reg;
        st_we     = 1'b0;
        st_wd     = st_q;
        node_addr = bi_reg;
        node_we   = 1'b0;
        node_wd   = {ll_reg, cl_reg};
        div_start = 1'b0;
        case (state_reg)
            ST_UPD_RA:
            begin
                pa_x = bi_reg;
                pa_y = cnt_reg;
            end
            ST_UPD_RB, ST_UPD_WR:
            begin
                pa_x = bj_reg;
                pa_y = cnt_reg;
            end
            ST_MV_RD:
            begin
                pa_x = nlast;
                pa_y = cnt_reg;
            end
            ST_MV_WR:
            begin
                pa_x = bi_reg;
                pa_y = cnt_reg;
            end
            default:
            begin
                pa_x = sc_i_reg;
                pa_y = sc_j_reg;
            end
        endcase
        st_addr = pair_addr(pa_x, pa_y);
        case (state_reg)
            ST_LOAD:
            begin
                st_addr = load_addr;
                st_we   = in_xfer;
                st_wd   = distance;
            end
            ST_INIT:
            begin
                node_addr = cnt_reg;
                node_we   = 1'b1;
                node_wd   = {ID_W'(cnt_reg), CW'(1)};
            end
            ST_LAB_B:   node_addr = bj_reg;
            ST_LAB_C:   node_addr = nlast;
            ST_UPD_DS:  div_start = 1'b1;
            ST_UPD_WR:
            begin
                st_we = 1'b1;
                st_wd = upd_val;
            end
            ST_MV_WR:
            begin
                st_we = 1'b1;
                st_wd = st_q;
            end
            ST_FIX_A:
            begin
                node_addr = bj_reg;
                node_we   = 1'b1;
                node_wd   = {new_label, sum_c};
            end
            ST_FIX_B:
            begin
                node_addr = bi_reg;
                node_we   = 1'b1;
            end
            default:
            begin
                node_we = 1'b0;
            end
        endcase
    end

    // distance store, one shared port
    always_ff @(posedge clk)
    begin
        if (st_we)
            store[st_addr] <= st_wd;
        st_q <= store[st_addr];
    end

    // cluster label and size memory
    always_ff @(posedge clk)
    begin
        if (node_we)
            nodes[node_addr] <= node_wd;
        node_q <= nodes[node_addr];
    end

    alc_divider #(
        .NUM_W(NUM_W),
        .DEN_W(CW)
    ) u_div (
        .clk  (clk),
        .rst_n(rst_n),
        .start(div_start),
        .num  (wsum_reg),
        .den  (sum_c),
        .quo  (div_quo),
        .stat (div_stat)
    );

    // configuration writes and reads
    assign cfg_wr = psel && penable && pwrite && pready;
    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_LINKAGE_MODE) ? CFG_DATA_W'(mode_reg) :
                    CFG_DATA_W'(elem_cnt_reg);

    // sequencer and control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_LOAD;
            elem_cnt_reg  <= ELEMENT_COUNT_RST;
            mode_reg      <= LINKAGE_MODE_RST;
            load_pos_reg  <= '0;
            n_reg         <= '0;
            total_reg     <= '0;
            cnt_reg       <= '0;
            sc_i_reg      <= '0;
            sc_j_reg      <= '0;
            sc_done_reg   <= 1'b0;
            p_vld_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr && paddr[2] == REG_ELEMENT_COUNT)
            begin
                elem_cnt_reg <= pwdata[COUNT_REG_W-1:0];
                load_pos_reg <= '0;
            end
            if (cfg_wr && paddr[2] == REG_LINKAGE_MODE)
                mode_reg <= pwdata[0];

            if (out_valid_reg && !out_stall)
                out_valid_reg <= 1'b0;

            p_vld_reg <= 1'b0;

            case (state_reg)
                ST_LOAD:
                begin
                    if (in_xfer)
                    begin
                        if ({1'b0, load_addr} + (AW+1)'(1) >= entries)
                        begin
                            load_pos_reg <= '0;
                            n_reg        <= eff_n;
                            total_reg    <= eff_n;
                            cnt_reg      <= '0;
                            state_reg    <= ST_INIT;
                        end
                        else
                        begin
                            load_pos_reg <= load_addr + AW'(1);
                        end
                    end
                end
                ST_INIT:
                begin
                    cnt_reg <= cnt_reg + IW'(1);
                    if (cnt_reg == IW'(total_reg - CW'(1)))
                    begin
                        sc_i_reg    <= IW'(1);
                        sc_j_reg    <= '0;
                        sc_done_reg <= 1'b0;
                        state_reg   <= ST_SCAN;
                    end
                end
                ST_SCAN:
                begin
                    if (!sc_done_reg)
                    begin
                        p_vld_reg <= 1'b1;
                        if (sc_row_end)
                        begin
                            sc_i_reg <= sc_i_reg + IW'(1);
                            sc_j_reg <= '0;
                            if (sc_i_reg == nlast)
                                sc_done_reg <= 1'b1;
                        end
                        else
                        begin
                            sc_j_reg <= sc_j_reg + IW'(1);
                        end
                    end
                    else if (!p_vld_reg)
                    begin
                        state_reg <= ST_LAB_A;
                    end
                end
                ST_LAB_A:   state_reg <= ST_LAB_B;
                ST_LAB_B:   state_reg <= ST_LAB_C;
                ST_LAB_C:   state_reg <= ST_LAB_D;
                ST_LAB_D:   state_reg <= ST_EMIT;
                ST_EMIT:
                begin
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        cnt_reg       <= '0;
                        if (n_reg == CW'(2))
                            state_reg <= ST_LOAD;
                        else
                            state_reg <= ST_UPD_RA;
                    end
                end
                ST_UPD_RA:
                begin
                    if (cnt_reg == bi_reg || cnt_reg == bj_reg)
                    begin
                        if (cnt_reg == nlast)
                        begin
                            cnt_reg   <= '0;
                            state_reg <= (bi_reg == nlast) ? ST_FIX_A : ST_MV_RD;
                        end
                        else
                        begin
                            cnt_reg <= cnt_reg + IW'(1);
                        end
                    end
                    else
                    begin
                        state_reg <= ST_UPD_RB;
                    end
                end
                ST_UPD_RB:  state_reg <= ST_UPD_OPB;
                ST_UPD_OPB:
                begin
                    state_reg <= (mode_reg == MODE_COMPLETE) ? ST_UPD_WR : ST_UPD_M1;
                end
                ST_UPD_M1:  state_reg <= ST_UPD_M2;
                ST_UPD_M2:  state_reg <= ST_UPD_DS;
                ST_UPD_DS:  state_reg <= ST_UPD_DW;
                ST_UPD_DW:
                begin
                    if (div_stat.done)
                        state_reg <= ST_UPD_WR;
                end
                ST_UPD_WR:
                begin
                    if (cnt_reg == nlast)
                    begin
                        cnt_reg   <= '0;
                        state_reg <= (bi_reg == nlast) ? ST_FIX_A : ST_MV_RD;
                    end
                    else
                    begin
                        cnt_reg   <= cnt_reg + IW'(1);
                        state_reg <= ST_UPD_RA;
                    end
                end
                ST_MV_RD:
                begin
                    if (cnt_reg == bi_reg)
                    begin
                        if (cnt_reg == nlast2)
                            state_reg <= ST_FIX_A;
                        else
                            cnt_reg <= cnt_reg + IW'(1);
                    end
                    else
                    begin
                        state_reg <= ST_MV_WR;
                    end
                end
                ST_MV_WR:
                begin
                    if (cnt_reg == nlast2)
                    begin
                        state_reg <= ST_FIX_A;
                    end
                    else
                    begin
                        cnt_reg   <= cnt_reg + IW'(1);
                        state_reg <= ST_MV_RD;
                    end
                end
                ST_FIX_A:   state_reg <= ST_FIX_B;
                ST_FIX_B:
                begin
                    n_reg       <= n_reg - CW'(1);
                    sc_i_reg    <= IW'(1);
                    sc_j_reg    <= '0;
                    sc_done_reg <= 1'b0;
                    state_reg   <= ST_SCAN;
                end
                default:    state_reg <= ST_LOAD;
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_SCAN)
        begin
            p_i_reg     <= sc_i_reg;
            p_j_reg     <= sc_j_reg;
            p_first_reg <= (sc_i_reg == IW'(1)) && (sc_j_reg == '0);
        end
        // running minimum, first strict minimum wins
        if (p_vld_reg && (p_first_reg || st_q < best_reg))
        begin
            best_reg <= st_q;
            bi_reg   <= p_i_reg;
            bj_reg   <= p_j_reg;
        end
        case (state_reg)
            ST_LAB_B:
            begin
                la_reg <= node_q[NODE_W-1:CW];
                ca_reg <= node_q[CW-1:0];
            end
            ST_LAB_C:
            begin
                lb_reg <= node_q[NODE_W-1:CW];
                cb_reg <= node_q[CW-1:0];
            end
            ST_LAB_D:
            begin
                ll_reg <= node_q[NODE_W-1:CW];
                cl_reg <= node_q[CW-1:0];
            end
            ST_UPD_RB:  op_a_reg <= st_q;
            ST_UPD_OPB: op_b_reg <= st_q;
            ST_UPD_M1:  prod_reg <= NUM_W'(op_a_reg) * NUM_W'(ca_reg);
            ST_UPD_M2:  wsum_reg <= prod_reg + NUM_W'(op_b_reg) * NUM_W'(cb_reg);
            default:
            begin
                prod_reg <= prod_reg;
            end
        endcase
        // merge record into the output register
        if (state_reg == ST_EMIT && out_free)
        begin
            left_reg  <= la_reg;
            right_reg <= lb_reg;
            mdist_reg <= best_reg;
            last_reg  <= (n_reg == CW'(2));
        end
    end

    assign out_valid      = out_valid_reg;
    assign left_cluster   = left_reg;
    assign right_cluster  = right_reg;
    assign merge_distance = mdist_reg;
    assign last_merge     = last_reg;

    // the two clusters of a merge record are always distinct
    a_distinct_ids: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (left_cluster != right_cluster))
        else $error("merge record joins a cluster with itself");

    // the divider is never restarted mid-division
    a_div_idle: assert property (@(posedge clk) disable iff (!rst_n)
        div_start |-> !div_stat.busy)
        else $error("divider started while busy");

    // store writes while loading come only from input transfers
    a_load_write: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_LOAD && st_we) |-> in_xfer)
        else $error("store written while loading without an input transfer");

    // the chosen pair is ordered row above column
    a_pair_order: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT) |-> (bj_reg < bi_reg))
        else $error("closest pair has column not below row");

    // at least two clusters remain while merging
    a_active: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_LOAD) |-> (n_reg >= CW'(2)))
        else $error("merge running with fewer than two clusters");

endmodule
